// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assertion macros for the checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, off while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked property, also checked during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/adpx3_pkg.sv =====
// ---------------------------------------------------------------------------
// adpx3_pkg
// Types, constants and the S-function transition weight shared by the
// additive differential count of three-input xor.
// ---------------------------------------------------------------------------
package adpx3_pkg;

   localparam int WORD_BITS   = 16;
   localparam int DIFF_W      = 16;
   localparam int COUNT_W     = 49;
   localparam int NSTATES     = 16;
   localparam int STATE_W     = 4;
   localparam int START_STATE = 8;
   localparam int WEIGHT_W    = 4;
   localparam int HALF        = NSTATES / 2;
   localparam int NPART       = 4;
   localparam int PART_LEN    = NSTATES / NPART;

   typedef logic [COUNT_W-1:0] count_type;
   typedef count_type [NSTATES-1:0] vec_type;

   typedef struct packed {
      logic [DIFF_W-1:0] diff_a;
      logic [DIFF_W-1:0] diff_b;
      logic [DIFF_W-1:0] diff_c;
      logic [DIFF_W-1:0] diff_out;
   } diff_type;

   // number of input bit choices leading from state u to state v
   // state bits: carry a, carry b, carry c, borrow plus one
   function automatic logic [WEIGHT_W-1:0] trans_weight(
      input logic ba, input logic bb, input logic bc, input logic bd,
      input logic [STATE_W-1:0] u, input logic [STATE_W-1:0] v);
      logic [WEIGHT_W-1:0] w;
      logic [2:0] jb;
      logic a1, b1, c1, a2, b2, c2, na, nb, nc, x1, x2;
      logic [1:0] y;
      w = '0;
      for (int j = 0; j < 8; j++) begin
         jb = 3'(j);
         a1 = jb[0];
         b1 = jb[1];
         c1 = jb[2];
         a2 = a1 ^ ba ^ u[0];
         b2 = b1 ^ bb ^ u[1];
         c2 = c1 ^ bc ^ u[2];
         na = (a1 & ba) | (a1 & u[0]) | (ba & u[0]);
         nb = (b1 & bb) | (b1 & u[1]) | (bb & u[1]);
         nc = (c1 & bc) | (c1 & u[2]) | (bc & u[2]);
         x1 = a1 ^ b1 ^ c1;
         x2 = a2 ^ b2 ^ c2;
         y  = {1'b0, x2} + 2'd1 - {1'b0, x1} + {1'b0, u[3]};
         if ((y[0] == bd) && ({y[1], nc, nb, na} == v)) begin
            w = w + WEIGHT_W'(1);
         end
      end
      return w;
   endfunction

endpackage

// ===== hdl/adpx3_cell.sv =====
// ---------------------------------------------------------------------------
// adpx3_cell
// One bit position of the S-function: multiplies the count vector by the
// transition table picked by the low difference bits, over two registers.
// ---------------------------------------------------------------------------
module adpx3_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  adpx3_pkg::vec_type   in_vec,
   input  adpx3_pkg::diff_type  in_diff,
   output logic                 out_valid,
   input  logic                 out_ready,
   output adpx3_pkg::vec_type   out_vec,
   output adpx3_pkg::diff_type  out_diff
);
   import adpx3_pkg::*;

   logic     va_ff, vb_ff;
   logic     ready_a, ready_b;
   vec_type  lo_in, hi_in;
   vec_type  lo_ff, hi_ff;
   vec_type  sum_in;
   vec_type  vec_ff;
   diff_type diff_a_in;
   diff_type diff_a_ff, diff_b_ff;
   logic     ba, bb, bc, bd;

   assign ready_b  = !vb_ff || out_ready;
   assign ready_a  = !va_ff || ready_b;
   assign in_ready = ready_a;

   assign ba = in_diff.diff_a[0];
   assign bb = in_diff.diff_b[0];
   assign bc = in_diff.diff_c[0];
   assign bd = in_diff.diff_out[0];

   // next cell sees the next bit in position zero
   always_comb begin
      diff_a_in.diff_a   = in_diff.diff_a >> 1;
      diff_a_in.diff_b   = in_diff.diff_b >> 1;
      diff_a_in.diff_c   = in_diff.diff_c >> 1;
      diff_a_in.diff_out = in_diff.diff_out >> 1;
   end

   // partial sums over the low and high halves of the source states
   always_comb begin
      for (int v = 0; v < NSTATES; v++) begin
         lo_in[v] = '0;
         hi_in[v] = '0;
         for (int u = 0; u < HALF; u++) begin
            lo_in[v] = lo_in[v] + COUNT_W'(in_vec[u] *
                       trans_weight(ba, bb, bc, bd, STATE_W'(u), STATE_W'(v)));
            hi_in[v] = hi_in[v] + COUNT_W'(in_vec[u+HALF] *
                       trans_weight(ba, bb, bc, bd, STATE_W'(u+HALF), STATE_W'(v)));
         end
      end
   end

   always_comb begin
      for (int v = 0; v < NSTATES; v++) begin
         sum_in[v] = lo_ff[v] + hi_ff[v];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         if (ready_a) begin
            va_ff <= in_valid;
         end
         if (ready_b) begin
            vb_ff <= va_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && ready_a) begin
         lo_ff     <= lo_in;
         hi_ff     <= hi_in;
         diff_a_ff <= diff_a_in;
      end
      if (va_ff && ready_b) begin
         vec_ff    <= sum_in;
         diff_b_ff <= diff_a_ff;
      end
   end

   assign out_valid = vb_ff;
   assign out_vec   = vec_ff;
   assign out_diff  = diff_b_ff;

endmodule

// ===== hdl/adpx3_sum.sv =====
// ---------------------------------------------------------------------------
// adpx3_sum
// Adds up the final count vector in a two-level registered tree and holds
// the result for the response channel.
// ---------------------------------------------------------------------------
module adpx3_sum (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  adpx3_pkg::vec_type         in_vec,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic [adpx3_pkg::COUNT_W-1:0] pair_count
);
   import adpx3_pkg::*;

   logic      vp_ff, vo_ff;
   logic      ready_p, ready_o;
   count_type part_in [NPART];
   count_type part_ff [NPART];
   count_type total_in;
   count_type total_ff;

   assign ready_o  = !vo_ff || out_ready;
   assign ready_p  = !vp_ff || ready_o;
   assign in_ready = ready_p;

   always_comb begin
      for (int k = 0; k < NPART; k++) begin
         part_in[k] = '0;
         for (int i = 0; i < PART_LEN; i++) begin
            part_in[k] = part_in[k] + in_vec[k*PART_LEN+i];
         end
      end
   end

   always_comb begin
      total_in = '0;
      for (int k = 0; k < NPART; k++) begin
         total_in = total_in + part_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vp_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         if (ready_p) begin
            vp_ff <= in_valid;
         end
         if (ready_o) begin
            vo_ff <= vp_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && ready_p) begin
         part_ff <= part_in;
      end
      if (vp_ff && ready_o) begin
         total_ff <= total_in;
      end
   end

   assign out_valid  = vo_ff;
   assign pair_count = total_ff;

endmodule

// ===== hdl/adp_xor3_sfunction_count.sv =====
// registers: two per bit cell, then a two-level sum tree that ends in the
// response register
// throughput: one transaction per cycle unless stalled; each stage has its own
// valid, so bubbles close up and a held response stalls only the stages behind it
// reset: synchronous, clears all stage valids; payload registers keep values
// ---------------------------------------------------------------------------
// adp_xor3_sfunction_count
// Counts input triples satisfying an additive differential of three-input
// xor with a chain of per-bit S-function cells, LSB cell first.
// ---------------------------------------------------------------------------
module adp_xor3_sfunction_count (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [adpx3_pkg::DIFF_W-1:0]  req_diff_a,
   input  logic [adpx3_pkg::DIFF_W-1:0]  req_diff_b,
   input  logic [adpx3_pkg::DIFF_W-1:0]  req_diff_c,
   input  logic [adpx3_pkg::DIFF_W-1:0]  req_diff_out,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [adpx3_pkg::COUNT_W-1:0] rsp_pair_count
);
   import adpx3_pkg::*;

   logic [WORD_BITS:0] valid_w;
   logic [WORD_BITS:0] ready_w;
   vec_type            vec_w  [WORD_BITS+1];
   diff_type           diff_w [WORD_BITS+1];
   vec_type            start_vec;

   // one count at the start state, with all carries zero
   always_comb begin
      start_vec              = '0;
      start_vec[START_STATE] = COUNT_W'(1);
   end

   assign valid_w[0] = req_valid;
   assign req_ready  = ready_w[0];
   assign vec_w[0]   = start_vec;
   assign diff_w[0]  = {req_diff_a, req_diff_b, req_diff_c, req_diff_out};

   for (genvar i = 0; i < WORD_BITS; i++) begin : g_cell
      adpx3_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid_w[i]),
         .in_ready  (ready_w[i]),
         .in_vec    (vec_w[i]),
         .in_diff   (diff_w[i]),
         .out_valid (valid_w[i+1]),
         .out_ready (ready_w[i+1]),
         .out_vec   (vec_w[i+1]),
         .out_diff  (diff_w[i+1])
      );
   end

   adpx3_sum u_sum (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (valid_w[WORD_BITS]),
      .in_ready   (ready_w[WORD_BITS]),
      .in_vec     (vec_w[WORD_BITS]),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .pair_count (rsp_pair_count)
   );

endmodule

// ===== hdl/adpx3_checker.sv =====
// ---------------------------------------------------------------------------
// adpx3_checker
// Port-level checks on the differential count block, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module adpx3_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic [adpx3_pkg::DIFF_W-1:0]  req_diff_a,
   input  logic [adpx3_pkg::DIFF_W-1:0]  req_diff_b,
   input  logic [adpx3_pkg::DIFF_W-1:0]  req_diff_c,
   input  logic [adpx3_pkg::DIFF_W-1:0]  req_diff_out,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic [adpx3_pkg::COUNT_W-1:0] rsp_pair_count
);
   import adpx3_pkg::*;

   localparam int OPEN_W = 8;
   localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(1) << (3 * WORD_BITS);

   logic [OPEN_W-1:0] open_ff, open_in;
   logic              req_acc, rsp_acc;
   logic [4*DIFF_W-1:0] req_all;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;
   assign req_all = {req_diff_a, req_diff_b, req_diff_c, req_diff_out};

   // transactions taken in but not yet answered
   always_comb begin
      open_in = open_ff;
      if (req_acc && !rsp_acc) begin
         open_in = open_ff + OPEN_W'(1);
      end else if (rsp_acc && !req_acc) begin
         open_in = open_ff - OPEN_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else begin
         open_ff <= open_in;
      end
   end

   `ASSERT_ALWAYS(a_rsp_idle_after_reset, clock, reset |=> !rsp_valid, "response valid after reset")
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pair_count), "stalled response changed")
   `ASSERT_CLK(a_no_spurious_rsp, clock, reset, rsp_valid |-> open_ff != '0, "response without a pending request")
   `ASSERT_CLK(a_count_bound, clock, reset, rsp_valid |-> rsp_pair_count <= MAX_COUNT, "count above the number of triples")
   `ASSERT_CLK(a_ready_when_empty, clock, reset, (open_ff == '0) && !$isunknown(req_all) |-> req_ready, "block not ready while empty")

endmodule

bind adp_xor3_sfunction_count adpx3_checker u_checker (.*);

// ===== verif/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for adp_xor3_sfunction_count: drives difference
// queries through the request channel with random gaps, predicts each
// satisfying-triple count with a bit-serial S-function walk, and compares
// every response against the oldest pending count.
// ---------------------------------------------------------------------------
module tb_top;
   import adpx3_pkg::*;

   localparam int IDLE_LIMIT  = 2000;
   localparam int TAIL_CYCLES = 2 * WORD_BITS + 12;
   localparam int MAX_REPORTS = 10;

   logic              clock        = 1'b0;
   logic              reset        = 1'b1;
   logic              req_valid    = 1'b0;
   logic              req_ready;
   logic [DIFF_W-1:0] req_diff_a   = '0;
   logic [DIFF_W-1:0] req_diff_b   = '0;
   logic [DIFF_W-1:0] req_diff_c   = '0;
   logic [DIFF_W-1:0] req_diff_out = '0;
   logic              rsp_valid;
   logic              rsp_ready    = 1'b0;
   logic [COUNT_W-1:0] rsp_pair_count;

   logic [COUNT_W-1:0] pending_counts [$];
   int mismatches  = 0;
   int idle_cycles = 0;
   int rsp_hold    = 0;
   bit no_idle     = 1'b0;

   adp_xor3_sfunction_count dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_diff_a     (req_diff_a),
      .req_diff_b     (req_diff_b),
      .req_diff_c     (req_diff_c),
      .req_diff_out   (req_diff_out),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_pair_count (rsp_pair_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // walks the carry/borrow automaton from the lsb, summing paths per state
   function automatic logic [COUNT_W-1:0] count_triples(
      input logic [DIFF_W-1:0] da, input logic [DIFF_W-1:0] db,
      input logic [DIFF_W-1:0] dc, input logic [DIFF_W-1:0] dd);
      longint unsigned paths [NSTATES];
      longint unsigned next_paths [NSTATES];
      longint unsigned total;
      logic ba, bb, bc, bd;
      logic a1, b1, c1, a2, b2, c2, na, nb, nc, x1, x2;
      logic [STATE_W-1:0] st;
      logic [STATE_W-1:0] nxt;
      logic [2:0] pick;
      logic [1:0] y;
      paths = '{default: 0};
      paths[START_STATE] = 1;
      for (int pos = 0; pos < WORD_BITS; pos++) begin
         // word bits beyond the field width read as zero
         ba = (pos < DIFF_W) ? da[pos] : 1'b0;
         bb = (pos < DIFF_W) ? db[pos] : 1'b0;
         bc = (pos < DIFF_W) ? dc[pos] : 1'b0;
         bd = (pos < DIFF_W) ? dd[pos] : 1'b0;
         next_paths = '{default: 0};
         for (int s = 0; s < NSTATES; s++) begin
            st = STATE_W'(s);
            if (paths[s] != 0) begin
               for (int j = 0; j < 8; j++) begin
                  pick = 3'(j);
                  a1 = pick[0];
                  b1 = pick[1];
                  c1 = pick[2];
                  a2 = a1 ^ ba ^ st[0];
                  b2 = b1 ^ bb ^ st[1];
                  c2 = c1 ^ bc ^ st[2];
                  na = (a1 & ba) | (a1 & st[0]) | (ba & st[0]);
                  nb = (b1 & bb) | (b1 & st[1]) | (bb & st[1]);
                  nc = (c1 & bc) | (c1 & st[2]) | (bc & st[2]);
                  x1 = a1 ^ b1 ^ c1;
                  x2 = a2 ^ b2 ^ c2;
                  // offset by one so the difference plus borrow stays in 0..3
                  y = 2'(int'(x2) + 1 - int'(x1) + int'(st[3]));
                  if (y[0] == bd) begin
                     nxt = {y[1], nc, nb, na};
                     next_paths[nxt] += paths[s];
                  end
               end
            end
         end
         paths = next_paths;
      end
      total = 0;
      for (int s = 0; s < NSTATES; s++) total += paths[s];
      return COUNT_W'(total);
   endfunction

   function automatic logic [DIFF_W-1:0] shaped_diff();
      logic [DIFF_W-1:0] v;
      case ($urandom_range(0, 4))
         0: v = DIFF_W'($urandom & $urandom & $urandom);
         1: v = DIFF_W'($urandom | $urandom | $urandom);
         2: v = DIFF_W'($urandom_range(0, 3));
         3: v = DIFF_W'(0) - DIFF_W'($urandom_range(0, 3));
         default: v = DIFF_W'($urandom);
      endcase
      return v;
   endfunction

   task automatic send_query(input logic [DIFF_W-1:0] da, input logic [DIFF_W-1:0] db,
                             input logic [DIFF_W-1:0] dc, input logic [DIFF_W-1:0] dd);
      int gap;
      logic [COUNT_W-1:0] want;
      gap  = no_idle ? 0 : $urandom_range(0, 6);
      want = count_triples(da, db, dc, dd);
      // valid only drops when a gap follows, so back-to-back stays high
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_diff_a   <= da;
      req_diff_b   <= db;
      req_diff_c   <= dc;
      req_diff_out <= dd;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_counts.push_back(want);
   endtask

   // mostly differentials that hold for some triple, so the count is nonzero
   task automatic send_random_query();
      logic [DIFF_W-1:0] da, db, dc, dd, a, b, c, sa, sb, sc;
      da = shaped_diff();
      db = shaped_diff();
      dc = shaped_diff();
      if ($urandom_range(0, 3) != 0) begin
         a  = DIFF_W'($urandom);
         b  = DIFF_W'($urandom);
         c  = DIFF_W'($urandom);
         sa = a + da;
         sb = b + db;
         sc = c + dc;
         dd = (sa ^ sb ^ sc) - (a ^ b ^ c);
      end else begin
         dd = ($urandom_range(0, 1) != 0) ? shaped_diff() : DIFF_W'($urandom);
      end
      send_query(da, db, dc, dd);
   endtask

   // the last transaction was just taken, so valid drops before waiting
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_counts.size() != 0) @(posedge clock);
   endtask

   task automatic test_corner_values();
      send_query(16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_query(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_query(16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
      send_query(16'h0000, 16'h0000, 16'h0000, 16'h0001);
      send_query(16'h0000, 16'h0000, 16'h0000, 16'h8000);
      send_query(16'h0001, 16'h0000, 16'h0000, 16'h0001);
      send_query(16'h0000, 16'h0001, 16'h0000, 16'h0001);
      send_query(16'h0000, 16'h0000, 16'h0001, 16'h0001);
      send_query(16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_query(16'h8000, 16'h0000, 16'h0000, 16'h8000);
      send_query(16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
      send_query(16'hFFFF, 16'h0001, 16'h0000, 16'h0000);
      send_query(16'h0001, 16'h0001, 16'h0000, 16'h0000);
      send_query(16'h0001, 16'h0001, 16'h0001, 16'h0003);
      send_query(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555);
      send_query(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA);
      send_query(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_query(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
      send_query(16'h1234, 16'hFEDC, 16'h0F0F, 16'hF0F0);
   endtask

   task automatic test_random_mix(input int n);
      for (int i = 0; i < n; i++) send_random_query();
   endtask

   // no idling on either side so the pipeline runs full
   task automatic test_back_to_back(input int n);
      no_idle = 1'b1;
      for (int i = 0; i < n; i++) send_random_query();
      no_idle = 1'b0;
   endtask

   task automatic test_drain_pause(input int rounds);
      for (int r = 0; r < rounds; r++) begin
         for (int i = 0; i < 25; i++) send_random_query();
         wait_drained();
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_corner_values();
      test_random_mix(600);
      test_back_to_back(150);
      test_drain_pause(3);
      test_random_mix(400);
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // response side: compare each accepted response, then a random stall
   always @(posedge clock) begin
      logic [COUNT_W-1:0] want;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_counts.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("unexpected response: pair_count=%0d", rsp_pair_count);
            end else begin
               want = pending_counts.pop_front();
               if (rsp_pair_count !== want) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display("pair_count mismatch: expected %0d, actual %0d",
                              want, rsp_pair_count);
               end
            end
            rsp_hold = no_idle ? 0 : $urandom_range(0, 6);
         end
         if (rsp_hold > 0) begin
            rsp_ready <= 1'b0;
            rsp_hold--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule
